/* design/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* design/rtt_pkg.sv */
package rtt_pkg;

  localparam int unsigned CntW  = 17;
  localparam int unsigned RttW  = 24;
  localparam int unsigned SumW  = 41;
  localparam int unsigned SqW   = 64;
  localparam int unsigned StepW = 7;

  // Only the low RttBits bits of a round-trip time are used
  localparam int unsigned RttBits = 24;

  localparam logic [CntW-1:0] MaxPings  = 17'd65536;
  localparam logic [CntW-1:0] LossScale = 17'd100000;
  localparam logic [RttW-1:0] RttAllOnes = 24'hFF_FFFF;

  // Iteration counts of the shared unit, one quotient bit or root bit per step
  localparam logic [StepW-1:0] LossSteps = 7'd33;
  localparam logic [StepW-1:0] AvgSteps  = 7'd41;
  localparam logic [StepW-1:0] MsqSteps  = 7'd64;
  localparam logic [StepW-1:0] SqrtSteps = 7'd24;

  // Command codes
  localparam logic CmdReply   = 1'b0;
  localparam logic CmdTimeout = 1'b1;

  typedef struct packed {
    logic            command;
    logic [RttW-1:0] rtt_us;
  } rtt_in_t;

  typedef struct packed {
    logic [CntW-1:0] transmitted_count;
    logic [CntW-1:0] received_count;
    logic [CntW-1:0] loss_milli_percent;
    logic [RttW-1:0] min_rtt_us;
    logic [RttW-1:0] max_rtt_us;
    logic [RttW-1:0] avg_rtt_us;
    logic [RttW-1:0] mdev_rtt_us;
    logic            full_flag;
  } rtt_out_t;

  // Sequencer to accumulator
  typedef struct packed {
    logic square_en;
    logic commit;
    logic reply;
  } acc_cmd_t;

  // Running statistics held by the accumulator
  typedef struct packed {
    logic [CntW-1:0] sent;
    logic [CntW-1:0] reply;
    logic [RttW-1:0] smallest;
    logic [RttW-1:0] largest;
    logic [SumW-1:0] sum;
    logic [SqW-1:0]  sumsq;
  } rtt_stats_t;

  // Sequencer to shared divide / square-root unit
  typedef struct packed {
    logic             start;
    logic             sqrt_mode;
    logic [StepW-1:0] steps;
  } unit_cmd_t;

endpackage

/* design/rtt_step_unit.sv */
// Shared restoring divider / digit-by-digit square root, one step per cycle.
// Operand is loaded left-aligned; after N steps the quotient sits in the
// low N bits of the shift register, the root in root_o.
module rtt_step_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rtt_pkg::unit_cmd_t              cmd_i,
  input  logic [rtt_pkg::SqW-1:0]         operand_i,
  input  logic [rtt_pkg::CntW-1:0]        divisor_i,
  output logic                            busy_o,
  output logic [rtt_pkg::SqW-1:0]         quotient_o,
  output logic [rtt_pkg::RttW-1:0]        root_o
);

  logic [rtt_pkg::SqW-1:0]   acc_q, acc_d;
  logic [24:0]               rem_q, rem_d;
  logic [rtt_pkg::RttW-1:0]  root_q, root_d;
  logic [rtt_pkg::CntW-1:0]  div_q, div_d;
  logic [rtt_pkg::StepW-1:0] cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      sqrt_q, sqrt_d;

  logic [26:0] cand;
  logic [26:0] trial;
  logic [27:0] diff;
  logic        fits;

  // Shared subtract-and-compare
  always_comb begin
    if (sqrt_q) begin
      cand  = {rem_q, acc_q[63:62]};
      trial = {1'b0, root_q, 2'b01};
    end else begin
      cand  = {9'd0, rem_q[16:0], acc_q[63]};
      trial = {10'd0, div_q};
    end
    diff = {1'b0, cand} - {1'b0, trial};
    fits = !diff[27];
  end

  // Step control
  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    root_d = root_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sqrt_d = sqrt_q;
    if (cmd_i.start) begin
      acc_d  = operand_i;
      rem_d  = '0;
      root_d = '0;
      div_d  = divisor_i;
      cnt_d  = cmd_i.steps;
      busy_d = 1'b1;
      sqrt_d = cmd_i.sqrt_mode;
    end else if (busy_q) begin
      rem_d = fits ? diff[24:0] : cand[24:0];
      if (sqrt_q) begin
        acc_d  = {acc_q[61:0], 2'b00};
        root_d = {root_q[22:0], fits};
      end else begin
        acc_d = {acc_q[62:0], fits};
      end
      cnt_d  = cnt_q - 7'd1;
      busy_d = (cnt_q != 7'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    div_q  <= div_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = acc_q;
  assign root_o     = root_q;

endmodule

/* design/rtt_accum.sv */
// Probe counters, min/max and sums. The square is registered in the cycle before
// the commit so the 64-bit add sees a flopped operand.
module rtt_accum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rtt_pkg::acc_cmd_t         cmd_i,
  input  logic [rtt_pkg::RttW-1:0]  rtt_i,
  output rtt_pkg::rtt_stats_t       stats_o
);

  logic [rtt_pkg::RttW-1:0] rtt;
  logic [47:0]              square_q;
  rtt_pkg::rtt_stats_t      stats_q, stats_d;

  assign rtt = {{(rtt_pkg::RttW - rtt_pkg::RttBits){1'b0}}, rtt_i[rtt_pkg::RttBits-1:0]};

  // Square of the round-trip time
  always_ff @(posedge clk_i) begin
    if (cmd_i.square_en) begin
      square_q <= 48'({24'd0, rtt} * {24'd0, rtt});
    end
  end

  // State update for one counted probe
  always_comb begin
    stats_d = stats_q;
    if (cmd_i.commit) begin
      stats_d.sent = stats_q.sent + 17'd1;
      if (cmd_i.reply) begin
        stats_d.reply = stats_q.reply + 17'd1;
        if (rtt < stats_q.smallest) stats_d.smallest = rtt;
        if (rtt > stats_q.largest)  stats_d.largest  = rtt;
        stats_d.sum   = stats_q.sum + {17'd0, rtt};
        stats_d.sumsq = stats_q.sumsq + {16'd0, square_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_q.sent     <= '0;
      stats_q.reply    <= '0;
      stats_q.smallest <= rtt_pkg::RttAllOnes;
      stats_q.largest  <= '0;
      stats_q.sum      <= '0;
      stats_q.sumsq    <= '0;
    end else begin
      stats_q <= stats_d;
    end
  end

  assign stats_o = stats_q;

endmodule

/* design/rtt_running_statistics.sv */
// Per request: the probe is counted unless full, then loss, average and mean square
// are divided out and the deviation square-rooted in turn on the shared unit;
// before the first reply only the loss division runs.
// A request is taken only in the idle state; a result left waiting in the output
// register holds the next one in the done state.
// Reset (rst_ni low, asynchronous): counters and sums cleared, min all ones, idle.
`include "assert_macros.svh"

module rtt_running_statistics (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rtt_pkg::rtt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rtt_pkg::rtt_out_t out_data_o
);

  typedef enum logic [12:0] {
    StIdle    = 13'b0000000000001,
    StSquare  = 13'b0000000000010,
    StCommit  = 13'b0000000000100,
    StLossMul = 13'b0000000001000,
    StLossGo  = 13'b0000000010000,
    StLossRun = 13'b0000000100000,
    StAvgGo   = 13'b0000001000000,
    StAvgRun  = 13'b0000010000000,
    StMsqGo   = 13'b0000100000000,
    StMsqRun  = 13'b0001000000000,
    StSqrtGo  = 13'b0010000000000,
    StSqrtRun = 13'b0100000000000,
    StDone    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  rtt_pkg::rtt_in_t    req_q;
  logic                full_q;
  logic [32:0]         loss_prod_q;
  logic [16:0]         loss_q;
  logic [23:0]         avg_q;
  logic [47:0]         avg_sq_q;
  logic [47:0]         var_q;
  logic [23:0]         mdev_q;
  logic                out_valid_q;
  rtt_pkg::rtt_out_t   out_q;

  rtt_pkg::acc_cmd_t   acc_cmd;
  rtt_pkg::rtt_stats_t stats;
  rtt_pkg::unit_cmd_t  unit_cmd;
  logic [63:0]         unit_operand;
  logic [16:0]         unit_divisor;
  logic                unit_busy;
  logic [63:0]         unit_quot;
  logic [23:0]         unit_root;

  logic                in_acc;
  logic                out_free;
  logic [16:0]         lost;
  logic [47:0]         meansq;
  logic                in_run;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign lost     = (stats.reply <= stats.sent) ? (stats.sent - stats.reply) : 17'd0;
  assign meansq   = unit_quot[47:0];
  assign in_run   = (state_q == StLossRun) || (state_q == StAvgRun) ||
                    (state_q == StMsqRun) || (state_q == StSqrtRun);

  rtt_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (acc_cmd),
    .rtt_i   (req_q.rtt_us),
    .stats_o (stats)
  );

  rtt_step_unit u_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (unit_cmd),
    .operand_i  (unit_operand),
    .divisor_i  (unit_divisor),
    .busy_o     (unit_busy),
    .quotient_o (unit_quot),
    .root_o     (unit_root)
  );

  // Sequencer
  always_comb begin
    state_d           = state_q;
    acc_cmd.square_en = 1'b0;
    acc_cmd.commit    = 1'b0;
    acc_cmd.reply     = (req_q.command == rtt_pkg::CmdReply);
    unit_cmd.start     = 1'b0;
    unit_cmd.sqrt_mode = 1'b0;
    unit_cmd.steps     = rtt_pkg::LossSteps;
    unit_operand       = {loss_prod_q, 31'd0};
    unit_divisor       = stats.sent;
    case (state_q)
      StIdle: begin
        if (in_acc) state_d = StSquare;
      end
      StSquare: begin
        acc_cmd.square_en = 1'b1;
        state_d = StCommit;
      end
      StCommit: begin
        acc_cmd.commit = !full_q;
        state_d = StLossMul;
      end
      StLossMul: begin
        state_d = StLossGo;
      end
      StLossGo: begin
        if (stats.sent == 17'd0) begin
          state_d = StAvgGo;
        end else begin
          unit_cmd.start = 1'b1;
          state_d = StLossRun;
        end
      end
      StLossRun: begin
        if (!unit_busy) state_d = StAvgGo;
      end
      StAvgGo: begin
        unit_cmd.steps = rtt_pkg::AvgSteps;
        unit_operand   = {stats.sum, 23'd0};
        unit_divisor   = stats.reply;
        if (stats.reply == 17'd0) begin
          state_d = StDone;
        end else begin
          unit_cmd.start = 1'b1;
          state_d = StAvgRun;
        end
      end
      StAvgRun: begin
        if (!unit_busy) state_d = StMsqGo;
      end
      StMsqGo: begin
        unit_cmd.start = 1'b1;
        unit_cmd.steps = rtt_pkg::MsqSteps;
        unit_operand   = stats.sumsq;
        unit_divisor   = stats.reply;
        state_d = StMsqRun;
      end
      StMsqRun: begin
        if (!unit_busy) state_d = StSqrtGo;
      end
      StSqrtGo: begin
        unit_cmd.start     = 1'b1;
        unit_cmd.sqrt_mode = 1'b1;
        unit_cmd.steps     = rtt_pkg::SqrtSteps;
        unit_operand       = {var_q, 16'd0};
        state_d = StSqrtRun;
      end
      StSqrtRun: begin
        if (!unit_busy) state_d = StDone;
      end
      StDone: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) req_q <= in_data_i;
    if (state_q == StSquare) full_q <= (stats.sent >= rtt_pkg::MaxPings);
    if (state_q == StLossMul) begin
      loss_prod_q <= 33'({17'd0, lost} * {17'd0, rtt_pkg::LossScale});
    end
    if (state_q == StLossGo && stats.sent == 17'd0) loss_q <= '0;
    if (state_q == StLossRun && !unit_busy) loss_q <= unit_quot[16:0];
    if (state_q == StAvgGo && stats.reply == 17'd0) begin
      avg_q  <= '0;
      mdev_q <= '0;
    end
    if (state_q == StAvgRun && !unit_busy) avg_q <= unit_quot[23:0];
    if (state_q == StMsqGo) avg_sq_q <= 48'({24'd0, avg_q} * {24'd0, avg_q});
    if (state_q == StMsqRun && !unit_busy) begin
      var_q <= (meansq >= avg_sq_q) ? (meansq - avg_sq_q) : 48'd0;
    end
    if (state_q == StSqrtRun && !unit_busy) mdev_q <= unit_root;
    // Result register
    if (state_q == StDone && out_free) begin
      out_q.transmitted_count  <= stats.sent;
      out_q.received_count     <= stats.reply;
      out_q.loss_milli_percent <= loss_q;
      out_q.min_rtt_us         <= (stats.reply != 17'd0) ? stats.smallest : 24'd0;
      out_q.max_rtt_us         <= (stats.reply != 17'd0) ? stats.largest : 24'd0;
      out_q.avg_rtt_us         <= avg_q;
      out_q.mdev_rtt_us        <= mdev_q;
      out_q.full_flag          <= full_q;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `ASSERT_IMPLY(a_reply_le_sent, 1'b1, stats.reply <= stats.sent)
  `ASSERT_IMPLY(a_sent_bounded, 1'b1, stats.sent <= rtt_pkg::MaxPings)
  `ASSERT_IMPLY(a_minmax_order, stats.reply != 17'd0, stats.smallest <= stats.largest)
  `ASSERT_IMPLY(a_unit_in_run, unit_busy, in_run)

endmodule
